### rtl/core/rtul_pkg.sv
// ----------------------------------------------------------------------------
// rtul_pkg
// Shared types and codes of the route table update and lookup engine.
// ----------------------------------------------------------------------------
package rtul_pkg;

	// command field of an input transaction
	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// configuration register indexes
	localparam logic REG_MY_ADDRESS        = 1'b0;
	localparam logic REG_BROADCAST_ADDRESS = 1'b1;

	// work kinds handed from the front to the engine
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NOP    = 3'd0;
	localparam kind_t KIND_BCAST  = 3'd1;
	localparam kind_t KIND_UPDATE = 3'd2;
	localparam kind_t KIND_LOOKUP = 3'd3;
	localparam kind_t KIND_TICK   = 3'd4;

	// update_action codes
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_REFRESH = 2'd1;
	localparam logic [1:0] ACT_KEEP    = 2'd2;
	localparam logic [1:0] ACT_NEW     = 2'd3;

	// route lifetime and sequence constants
	localparam logic [3:0] LIFE_FULL      = 4'd15;
	localparam logic [4:0] LIFE_ABOVE_MAX = 5'd16;
	localparam logic [8:0] SEQ_WRAP_GAP   = 9'd240;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] dest;
		logic [3:0] hops;
		logic [7:0] seq;
		logic [7:0] via;
	} item_t;

	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] next_hop;
		logic [7:0] seq;
		logic [3:0] hops;
		logic [3:0] life;
	} entry_t;

	typedef struct packed {
		logic       route_found;
		logic [7:0] next_hop;
		logic       request_route;
		logic [1:0] update_action;
	} result_t;

endpackage

### rtl/core/rtul_fifo.sv
// ----------------------------------------------------------------------------
// rtul_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module rtul_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	// a lone accepted transaction grows the fill count by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue fill count did not follow a push");
`endif

endmodule

### rtl/core/rtul_front.sv
// ----------------------------------------------------------------------------
// rtul_front
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module rtul_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      command,
	input  logic [7:0]      dest_address,
	input  logic [3:0]      hop_count,
	input  logic [7:0]      seq_number,
	input  logic [7:0]      via_address,
	input  logic [7:0]      my_address,
	input  logic [7:0]      broadcast_address,
	input  logic            item_pop,
	output rtul_pkg::item_t item,
	output logic            item_empty
);

	rtul_pkg::item_t cls_item;

	// classify: own-address updates and broadcast lookups need no table scan
	always_comb begin
		cls_item.dest = dest_address;
		cls_item.hops = hop_count;
		cls_item.seq  = seq_number;
		cls_item.via  = via_address;
		unique case (command)
			rtul_pkg::CMD_UPDATE: begin
				cls_item.kind = (dest_address == my_address) ?
					rtul_pkg::KIND_NOP : rtul_pkg::KIND_UPDATE;
			end
			rtul_pkg::CMD_LOOKUP: begin
				cls_item.kind = (dest_address == broadcast_address) ?
					rtul_pkg::KIND_BCAST : rtul_pkg::KIND_LOOKUP;
			end
			rtul_pkg::CMD_TICK: begin
				cls_item.kind = rtul_pkg::KIND_TICK;
			end
			default: begin
				cls_item.kind = rtul_pkg::KIND_NOP;
			end
		endcase
	end

	// queue between front and engine
	rtul_fifo #(
		.WIDTH($bits(rtul_pkg::item_t))
	) u_item_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (item),
		.empty (item_empty)
	);

endmodule

### rtl/core/rtul_engine.sv
// ----------------------------------------------------------------------------
// rtul_engine
// Route table memory and the scan sequencer that runs updates, lookups of
// a non-broadcast address and ticks one entry per cycle.
// ----------------------------------------------------------------------------
module rtul_engine #(
	parameter int unsigned ROUTE_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtul_pkg::item_t   item,
	input  logic              item_empty,
	output logic              item_pop,
	input  logic [7:0]        broadcast_address,
	input  logic              res_full,
	output logic              res_push,
	output rtul_pkg::result_t res
);

	localparam int unsigned IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	rtul_pkg::entry_t route_mem [ROUTE_ENTRIES];
	logic [ROUTE_ENTRIES-1:0] valid_q;

	logic [1:0]       state_q;
	rtul_pkg::item_t  cur_q;
	logic             issue_q;
	logic [IDX_W-1:0] issue_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	rtul_pkg::entry_t ent_raw_s1;
	logic             ent_valid_s1;
	logic [4:0]       least_q;
	logic [IDX_W-1:0] victim_q;
	logic             matched_q;
	logic             replaced_q;
	logic             found_q;
	logic [7:0]       hop_q;

	rtul_pkg::entry_t ent;
	rtul_pkg::entry_t new_entry;
	logic             dest_hit;
	logic             seq_older;
	logic             upd_replace;
	logic             proc;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	rtul_pkg::entry_t wr_data;

	// entry under inspection, never-written entries read as zero
	assign ent = ent_valid_s1 ? ent_raw_s1 : '0;

	assign new_entry = '{dest: cur_q.dest, next_hop: cur_q.via, seq: cur_q.seq,
		hops: cur_q.hops, life: rtul_pkg::LIFE_FULL};

	// update decision for one entry
	assign dest_hit  = (ent.dest == cur_q.dest);
	assign seq_older = (ent.seq < cur_q.seq) ||
		({1'b0, ent.seq} > ({1'b0, cur_q.seq} + rtul_pkg::SEQ_WRAP_GAP)) ||
		(ent.life == 4'd0);
	assign upd_replace = dest_hit &&
		((ent.seq == cur_q.seq) ? (ent.hops > cur_q.hops) : seq_older);

	assign proc    = (state_q == ST_SCAN) && vld_s1;
	assign rd_en   = (state_q == ST_SCAN) && issue_q;
	assign rd_addr = issue_idx_q;

	// write port: scan write-back or victim install
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = new_entry;
		if (proc) begin
			if (cur_q.kind == rtul_pkg::KIND_UPDATE && upd_replace) begin
				wr_en = 1'b1;
			end else if (cur_q.kind == rtul_pkg::KIND_TICK && ent.life != 4'd0) begin
				wr_en        = 1'b1;
				wr_data      = ent;
				wr_data.life = ent.life - 4'd1;
			end
		end else if (state_q == ST_FIN && cur_q.kind == rtul_pkg::KIND_UPDATE &&
				!matched_q) begin
			wr_en   = 1'b1;
			wr_addr = victim_q;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			route_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ent_raw_s1 <= route_mem[rd_addr];
		end
	end

	// per-entry written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			ent_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ent_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign item_pop = (state_q == ST_IDLE) && !item_empty;
	assign res_push = (state_q == ST_FIN) && !res_full;

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			issue_idx_q <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			cur_q       <= '0;
			least_q     <= rtul_pkg::LIFE_ABOVE_MAX;
			victim_q    <= '0;
			matched_q   <= 1'b0;
			replaced_q  <= 1'b0;
			found_q     <= 1'b0;
			hop_q       <= 8'd0;
		end else begin
			vld_s1 <= rd_en;
			idx_s1 <= rd_addr;
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						cur_q       <= item;
						least_q     <= rtul_pkg::LIFE_ABOVE_MAX;
						victim_q    <= '0;
						matched_q   <= 1'b0;
						replaced_q  <= 1'b0;
						found_q     <= 1'b0;
						hop_q       <= 8'd0;
						issue_idx_q <= '0;
						case (item.kind) inside
							rtul_pkg::KIND_UPDATE, rtul_pkg::KIND_LOOKUP,
							rtul_pkg::KIND_TICK: begin
								issue_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// read issue side
					if (issue_q) begin
						if (issue_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							issue_idx_q <= issue_idx_q + 1'b1;
						end
					end
					// registered entry side
					if (proc) begin
						if (cur_q.kind == rtul_pkg::KIND_UPDATE) begin
							if ({1'b0, ent.life} < least_q) begin
								least_q  <= {1'b0, ent.life};
								victim_q <= idx_s1;
							end
							if (dest_hit) begin
								matched_q <= 1'b1;
							end
							if (upd_replace) begin
								replaced_q <= 1'b1;
							end
						end
						if (cur_q.kind == rtul_pkg::KIND_LOOKUP && !found_q && dest_hit &&
								ent.life != 4'd0) begin
							found_q <= 1'b1;
							hop_q   <= ent.next_hop;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result formation
	always_comb begin
		res = '0;
		case (cur_q.kind)
			rtul_pkg::KIND_BCAST: begin
				res.route_found = 1'b1;
				res.next_hop    = broadcast_address;
			end
			rtul_pkg::KIND_LOOKUP: begin
				if (found_q) begin
					res.route_found = 1'b1;
					res.next_hop    = hop_q;
				end else begin
					res.next_hop      = broadcast_address;
					res.request_route = 1'b1;
				end
			end
			rtul_pkg::KIND_UPDATE: begin
				if (!matched_q) begin
					res.update_action = rtul_pkg::ACT_NEW;
				end else if (replaced_q) begin
					res.update_action = rtul_pkg::ACT_REFRESH;
				end else begin
					res.update_action = rtul_pkg::ACT_KEEP;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a scan write-back never lands on the entry being read
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table write collides with table read");

	// a taken transaction always leaves idle
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> (state_q == ST_SCAN || state_q == ST_FIN))
		else $error("engine stayed idle after taking a transaction");

	// the last entry closes the scan
	a_scan_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && idx_s1 == LAST_IDX) |=> (state_q == ST_FIN))
		else $error("scan did not close after the last entry");
`endif

endmodule

### rtl/core/route_table_update_lookup.sv
// ----------------------------------------------------------------------------
// route_table_update_lookup
// Mesh routing table with updates, lookups and aging ticks.
// ----------------------------------------------------------------------------
// Every transaction pushed in gives exactly one result, in order. Updates,
// lookups of a non-broadcast address and ticks walk the route table one
// entry per cycle through the single read port of the table memory: the
// engine takes the transaction, issues the reads and inspects their
// registered data, then finishes and delivers the result, which waits
// while the result queue is full. Broadcast lookups, updates for this
// node's own address and unused commands skip the walk. Two-entry queues
// on the input and result sides let either side stall while the engine
// keeps working. No clearing pass is needed after reset. Configuration
// writes are taken at any time but belong to idle periods.
module route_table_update_lookup #(
	parameter int unsigned ROUTE_ENTRIES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] dest_address,
	input  logic [3:0] hop_count,
	input  logic [7:0] seq_number,
	input  logic [7:0] via_address,
	output logic       empty,
	input  logic       pop,
	output logic       route_found,
	output logic [7:0] next_hop,
	output logic       request_route,
	output logic [1:0] update_action
);

	logic [7:0]        my_address_q;
	logic [7:0]        broadcast_address_q;
	rtul_pkg::item_t   item;
	logic              item_empty;
	logic              item_pop;
	logic              res_full;
	logic              res_push;
	rtul_pkg::result_t res;
	rtul_pkg::result_t res_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_address_q        <= 8'd0;
			broadcast_address_q <= 8'd255;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rtul_pkg::REG_MY_ADDRESS:        my_address_q        <= cfg_data;
				rtul_pkg::REG_BROADCAST_ADDRESS: broadcast_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	rtul_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.command          (command),
		.dest_address     (dest_address),
		.hop_count        (hop_count),
		.seq_number       (seq_number),
		.via_address      (via_address),
		.my_address       (my_address_q),
		.broadcast_address(broadcast_address_q),
		.item_pop         (item_pop),
		.item             (item),
		.item_empty       (item_empty)
	);

	// back: table engine
	rtul_engine #(
		.ROUTE_ENTRIES(ROUTE_ENTRIES)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (item),
		.item_empty       (item_empty),
		.item_pop         (item_pop),
		.broadcast_address(broadcast_address_q),
		.res_full         (res_full),
		.res_push         (res_push),
		.res              (res)
	);

	// result queue
	rtul_fifo #(
		.WIDTH($bits(rtul_pkg::result_t))
	) u_result_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	assign route_found   = res_head.route_found;
	assign next_hop      = res_head.next_hop;
	assign request_route = res_head.request_route;
	assign update_action = res_head.update_action;

endmodule
